// ===== hdl/mwa_pkg.sv =====
// Shared types and constants for the max window average block.
package mwa_pkg;

    localparam int SUM_BITS  = 42;
    localparam int AVG_BITS  = 48;
    localparam int FRAC_BITS = 16;
    localparam int WLEN_BITS = 11;
    localparam int DATA_BITS = 32;

    // Divider: magnitude of the sum shifted left by the fraction bits.
    localparam int DVD_BITS  = SUM_BITS + FRAC_BITS;
    localparam int DIV_STEPS = DVD_BITS;
    localparam int DCNT_BITS = $clog2(DIV_STEPS);

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // One classified sample on its way to the back end.
    typedef struct packed {
        logic signed [DATA_BITS-1:0] add;      // new sample, sign extended
        logic signed [DATA_BITS-1:0] sub_val;  // sample leaving the window, or zero
        logic                        full;     // a full window exists after this sample
        logic                        last;     // end of sequence
        logic [WLEN_BITS-1:0]        k;        // effective window length
    } t_item;

endpackage

// ===== hdl/mwa_front.sv =====
// Front end: config register, sample ring store, slot and fill counters, classification.
module mwa_front import mwa_pkg::*; #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [WLEN_BITS-1:0] i_cfg_wdata,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [DATA_BITS-1:0] i_s_tdata,
    input  logic                 i_s_tlast,
    input  logic [QCW-1:0]       i_q_count,
    output logic                 o_push,
    output t_item                o_item
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FW = $clog2(MAX_WINDOW + 1);

    logic [WLEN_BITS-1:0]   r_window_len;
    logic [AW-1:0]          r_ws;
    logic [FW-1:0]          r_filled;
    logic [SAMPLE_BITS-1:0] r_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] r_rd;

    logic                        r_s1_valid;
    logic signed [DATA_BITS-1:0] r_s1_sample;
    logic                        r_s1_sub;
    logic                        r_s1_full;
    logic                        r_s1_last;
    logic [WLEN_BITS-1:0]        r_s1_k;

    logic [WLEN_BITS-1:0]          eff_k;
    logic                          accept;
    logic [31:0]                   prior32, k32, filled_inc32, old32;
    logic                          sub_now, full_now;
    logic [AW-1:0]                 old_addr, n_ws;
    logic [FW-1:0]                 n_filled;
    logic signed [SAMPLE_BITS-1:0] smp, rd_s;

    always_comb begin
        if (r_window_len == '0) begin
            eff_k = WLEN_BITS'(1);
        end else if (32'(r_window_len) > 32'(MAX_WINDOW)) begin
            eff_k = WLEN_BITS'(MAX_WINDOW);
        end else begin
            eff_k = r_window_len;
        end
    end

    assign o_s_tready = (32'(i_q_count) + 32'(r_s1_valid)) < 32'(QDEPTH);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        prior32      = 32'(r_filled);
        k32          = 32'(eff_k);
        sub_now      = prior32 >= k32;
        filled_inc32 = (prior32 < 32'(MAX_WINDOW)) ? prior32 + 32'd1 : prior32;
        full_now     = filled_inc32 >= k32;
        n_filled     = FW'(filled_inc32);
        // slot that drops out of the window, modulo the store depth
        if (32'(r_ws) >= k32) begin
            old32 = 32'(r_ws) - k32;
        end else begin
            old32 = 32'(r_ws) + 32'(MAX_WINDOW) - k32;
        end
        old_addr = old32[AW-1:0];
        n_ws     = (32'(r_ws) == 32'(MAX_WINDOW - 1)) ? '0 : AW'(32'(r_ws) + 32'd1);
    end

    assign smp = i_s_tdata[SAMPLE_BITS-1:0];

    // ring store, read-before-write on the same slot
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_ws] <= i_s_tdata[SAMPLE_BITS-1:0];
            r_rd        <= r_mem[old_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WLEN_BITS'(1);
            r_ws         <= '0;
            r_filled     <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window_len <= i_cfg_wdata;
            end
            r_s1_valid <= accept;
            if (accept) begin
                if (i_s_tlast) begin
                    r_ws     <= '0;
                    r_filled <= '0;
                end else begin
                    r_ws     <= n_ws;
                    r_filled <= n_filled;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample <= DATA_BITS'(smp);
            r_s1_sub    <= sub_now;
            r_s1_full   <= full_now;
            r_s1_last   <= i_s_tlast;
            r_s1_k      <= eff_k;
        end
    end

    assign rd_s = r_rd;

    always_comb begin
        o_push         = r_s1_valid;
        o_item.add     = r_s1_sample;
        o_item.sub_val = r_s1_sub ? DATA_BITS'(rd_s) : '0;
        o_item.full    = r_s1_full;
        o_item.last    = r_s1_last;
        o_item.k       = r_s1_k;
    end

endmodule

// ===== hdl/mwa_queue.sv =====
// Small FIFO of classified samples between front and back end.
module mwa_queue import mwa_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  t_item          i_item,
    input  logic           i_pop,
    output t_item          o_item,
    output logic [QCW-1:0] o_count
);

    t_item          r_slots [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_item  = r_slots[r_rp];
    assign o_count = r_count;

endmodule

// ===== hdl/mwa_div.sv =====
// Bit-serial signed divider: (value << 16) / divisor, truncated, saturated to 48 bits.
module mwa_div import mwa_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SUM_BITS-1:0] i_value,
    input  logic [WLEN_BITS-1:0]       i_divisor,
    output logic                       o_done,
    output logic signed [AVG_BITS-1:0] o_quot
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIN  = 2'd2;

    localparam logic [DVD_BITS-1:0] Q_NEG_LIM = DVD_BITS'(1) << (AVG_BITS - 1);
    localparam logic [DVD_BITS-1:0] Q_POS_LIM = Q_NEG_LIM - DVD_BITS'(1);

    logic [1:0]                 r_state;
    logic [DCNT_BITS-1:0]       r_cnt;
    logic [DVD_BITS-1:0]        r_dvd;
    logic [WLEN_BITS-1:0]       r_rem;
    logic [WLEN_BITS-1:0]       r_div;
    logic                       r_neg;
    logic                       r_done;
    logic signed [AVG_BITS-1:0] r_quot;

    logic [WLEN_BITS:0]   trial;
    logic                 qbit;
    logic [WLEN_BITS-1:0] n_rem;
    logic [SUM_BITS-1:0]  mag;
    logic [DVD_BITS-1:0]  neg_q;

    always_comb begin
        trial = {r_rem, r_dvd[DVD_BITS-1]};
        qbit  = trial >= {1'b0, r_div};
        n_rem = qbit ? WLEN_BITS'(trial - {1'b0, r_div}) : trial[WLEN_BITS-1:0];
        mag   = i_value[SUM_BITS-1] ? SUM_BITS'(-i_value) : SUM_BITS'(i_value);
        neg_q = -r_dvd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    if (r_cnt == DCNT_BITS'(DIV_STEPS - 1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    r_state <= D_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_dvd <= {mag, {FRAC_BITS{1'b0}}};
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_div <= i_divisor;
                    r_neg <= i_value[SUM_BITS-1];
                end
            end
            D_RUN: begin
                r_dvd <= {r_dvd[DVD_BITS-2:0], qbit};
                r_rem <= n_rem;
                r_cnt <= r_cnt + DCNT_BITS'(1);
            end
            D_FIN: begin
                if (r_neg) begin
                    r_quot <= (r_dvd > Q_NEG_LIM) ? AVG_BITS'(Q_NEG_LIM) : neg_q[AVG_BITS-1:0];
                end else begin
                    r_quot <= (r_dvd > Q_POS_LIM) ? AVG_BITS'(Q_POS_LIM) : r_dvd[AVG_BITS-1:0];
                end
            end
            default: r_cnt <= '0;
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hdl/mwa_back.sv =====
// Back end: running window sum, best sum tracking, result register.
module mwa_back import mwa_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [QCW-1:0]             i_q_count,
    input  t_item                      i_item,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SUM_BITS-1:0] o_max_sum,
    output logic signed [AVG_BITS-1:0] o_max_avg,
    output logic                       o_too_short
);

    localparam logic [1:0] ST_ACC = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    logic [1:0]                 r_state;
    logic signed [SUM_BITS-1:0] r_run, r_best, r_osum;
    logic                       r_bvalid;
    logic signed [AVG_BITS-1:0] r_oavg;
    logic                       r_short;

    logic signed [SUM_BITS-1:0] n_run, n_best;
    logic                       n_bvalid;
    logic                       pop, div_start, div_done;
    logic signed [AVG_BITS-1:0] div_quot;

    always_comb begin
        n_run    = r_run + SUM_BITS'(i_item.add) - SUM_BITS'(i_item.sub_val);
        n_best   = (i_item.full && (!r_bvalid || n_run > r_best)) ? n_run : r_best;
        n_bvalid = r_bvalid | i_item.full;
    end

    assign pop       = (i_q_count != '0) && (r_state == ST_ACC);
    assign div_start = pop && i_item.last && n_bvalid;

    mwa_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_value   (n_best),
        .i_divisor (i_item.k),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_ACC;
            r_run    <= '0;
            r_best   <= '0;
            r_bvalid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_ACC: begin
                    if (pop) begin
                        if (i_item.last) begin
                            r_run    <= '0;
                            r_best   <= '0;
                            r_bvalid <= 1'b0;
                            r_state  <= n_bvalid ? ST_DIV : ST_OUT;
                        end else begin
                            r_run    <= n_run;
                            r_best   <= n_best;
                            r_bvalid <= n_bvalid;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_state <= ST_ACC;
                    end
                end
                default: r_state <= ST_ACC;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_item.last) begin
            r_osum  <= n_bvalid ? n_best : '0;
            r_oavg  <= '0;
            r_short <= !n_bvalid;
        end else if (div_done) begin
            r_oavg <= div_quot;
        end
    end

    assign o_pop       = pop;
    assign o_valid     = (r_state == ST_OUT);
    assign o_max_sum   = r_osum;
    assign o_max_avg   = r_oavg;
    assign o_too_short = r_short;

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_too_short) |-> (o_max_sum == '0 && o_max_avg == '0))
        else $error("too_short result carries nonzero fields");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside divide state");

    a_out_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> (r_state == ST_ACC))
        else $error("back end did not return to accumulate after result");

    a_div_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && $past(r_state) == ST_DIV) |-> $past(div_done))
        else $error("result shown before average was ready");

endmodule

// ===== hdl/max_window_average.sv =====
// Top level of the max window average block: front end, queue, back end.
// A sample passes the front-end stage register and the queue before the back end sums it; a result
//   shows in the cycle after its final sample is summed when too short, else once the divider is done.
// Throughput: one sample per cycle while the queue has room; each sequence end that is not too short
//   costs the back end a divide plus the result wait, while the front fills the 4-entry queue and then stalls.
// Reset (i_rst_n low, synchronous): counters, sums, queue and FSMs clear, window_len = 1;
//   the sample store is not cleared and no clearing pass is run.
module max_window_average import mwa_pkg::*; #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: window_len
    input  logic                 i_cfg_we,
    input  logic [WLEN_BITS-1:0] i_cfg_wdata,
    // sample stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [31:0]          i_s_tdata,   // [31:0] sample
    input  logic                 i_s_tlast,   // last sample of the sequence
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [95:0]          o_m_tdata,   // [41:0] max_sum, [89:42] max_average, rest zero
    output logic                 o_m_tuser    // [0] too_short
);

    logic                       push, pop;
    t_item                      front_item, head_item;
    logic [QCW-1:0]             q_count;
    logic signed [SUM_BITS-1:0] max_sum;
    logic signed [AVG_BITS-1:0] max_avg;

    // Front: window length, ring store write and old-sample read, per-sample flags.
    mwa_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_q_count   (q_count),
        .o_push      (push),
        .o_item      (front_item)
    );

    // Queue lets the front keep taking samples while the back divides or waits.
    mwa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_count (q_count)
    );

    // Back: running sum, best sum, average, result register.
    mwa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_count   (q_count),
        .i_item      (head_item),
        .o_pop       (pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_max_sum   (max_sum),
        .o_max_avg   (max_avg),
        .o_too_short (o_m_tuser)
    );

    assign o_m_tdata = {6'b0, max_avg, max_sum};

endmodule
